>>> rtl/ptme_pkg.sv
// ----------------------------------------------------------------------------
// ptme_pkg: shared types and constants of the page table map/unmap engine
// Pool sizing, entry bit positions, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptme_pkg;

    // pool sizing
    localparam int NUM_TABLES = 16;
    localparam int ENTRIES    = 512;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CNT_W      = $clog2(NUM_TABLES + 1);
    localparam int MEM_DEPTH  = NUM_TABLES * ENTRIES;
    localparam int MEM_AW     = TBL_W + IDX_W;

    // field widths
    localparam int PA_W    = 52;
    localparam int VA_W    = 48;
    localparam int FRAME_W = 40;
    localparam int VPN_W   = 36;
    localparam int FLAGS_W = 12;
    localparam int ENTRY_W = 64;

    // entry bits
    localparam logic [FLAGS_W-1:0] BIT_P  = 12'h001;
    localparam logic [FLAGS_W-1:0] BIT_RW = 12'h002;
    localparam logic [FLAGS_W-1:0] BIT_PS = 12'h080;
    localparam int PS_POS = 7;

    // request kinds: bit 1 selects unmap
    localparam logic [1:0] KIND_MAP_4K = 2'd0;
    localparam logic [1:0] KIND_MAP_2M = 2'd1;
    localparam int         KIND_UNMAP_BIT = 1;

    // walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef enum logic [2:0] {
        ST_DONE          = 3'd0,
        ST_POOL_EXHAUST  = 3'd1,
        ST_NOT_PRESENT   = 3'd2,
        ST_LARGE_PAGE    = 3'd3,
        ST_OUTSIDE_POOL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_NEXT,
        S_LEAF,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    clear_wr;   // reset sweep: zero one entry
        logic    load_req;   // capture request, start at root
        logic    rd;         // read entry of current table at current level
        logic    zero_wr;    // allocation sweep: zero one entry of new table
        logic    link_wr;    // link new table, descend into it
        logic    follow;     // descend into the table the entry points at
        logic    leaf_wr;    // write leaf or clear it on unmap
        logic    fail;       // record failure code
        status_t fail_code;
        logic    load_out;   // present the result
    } ptme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clear_last;
        logic       zero_last;
        logic       present;
        logic       ps_set;
        logic       in_pool;
        logic       pool_full;
        logic       unmap;
        logic       large_req;
        logic [1:0] level;
        logic       out_free;
    } ptme_stat_t;

endpackage

`default_nettype wire

>>> rtl/ptme_ctrl.sv
// ----------------------------------------------------------------------------
// ptme_ctrl: walk controller
// Sequences the reset sweep, the level reads, table allocation and the
// final leaf write of each successful request.
// ----------------------------------------------------------------------------
`default_nettype none

module ptme_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire ptme_pkg::ptme_stat_t stat,
    output ptme_pkg::ptme_cmd_t       cmd
);

    ptme_pkg::state_t state_reg;
    ptme_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptme_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptme_pkg::S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ptme_pkg::S_IDLE;
                end
            end
            ptme_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptme_pkg::S_READ;
                end
            end
            ptme_pkg::S_READ:
            begin
                state_next = ptme_pkg::S_EVAL;
            end
            ptme_pkg::S_EVAL:
            begin
                priority if (!stat.present)
                begin
                    if (stat.unmap || stat.pool_full)
                    begin
                        state_next = ptme_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ptme_pkg::S_ZERO;
                    end
                end
                else if (stat.unmap && stat.level == ptme_pkg::LVL_PD && stat.ps_set)
                begin
                    state_next = ptme_pkg::S_DONE;
                end
                else if (!stat.in_pool)
                begin
                    state_next = ptme_pkg::S_DONE;
                end
                else
                begin
                    state_next = ptme_pkg::S_NEXT;
                end
            end
            ptme_pkg::S_ZERO:
            begin
                if (stat.zero_last)
                begin
                    state_next = ptme_pkg::S_LINK;
                end
            end
            ptme_pkg::S_LINK:
            begin
                state_next = ptme_pkg::S_NEXT;
            end
            ptme_pkg::S_NEXT:
            begin
                if (stat.level == ptme_pkg::LVL_PT ||
                    (stat.level == ptme_pkg::LVL_PD && stat.large_req && !stat.unmap))
                begin
                    state_next = ptme_pkg::S_LEAF;
                end
                else
                begin
                    state_next = ptme_pkg::S_READ;
                end
            end
            ptme_pkg::S_LEAF:
            begin
                state_next = ptme_pkg::S_DONE;
            end
            ptme_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ptme_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptme_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        cmd.fail_code = ptme_pkg::ST_DONE;
        in_stall  = (state_reg != ptme_pkg::S_IDLE);
        unique case (state_reg)
            ptme_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ptme_pkg::S_IDLE:
            begin
                cmd.load_req = in_valid;
            end
            ptme_pkg::S_READ:
            begin
                cmd.rd = 1'b1;
            end
            ptme_pkg::S_EVAL:
            begin
                priority if (!stat.present)
                begin
                    if (stat.unmap)
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ptme_pkg::ST_NOT_PRESENT;
                    end
                    else if (stat.pool_full)
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ptme_pkg::ST_POOL_EXHAUST;
                    end
                end
                else if (stat.unmap && stat.level == ptme_pkg::LVL_PD && stat.ps_set)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ptme_pkg::ST_LARGE_PAGE;
                end
                else if (!stat.in_pool)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ptme_pkg::ST_OUTSIDE_POOL;
                end
                else
                begin
                    cmd.follow = 1'b1;
                end
            end
            ptme_pkg::S_ZERO:
            begin
                cmd.zero_wr = 1'b1;
            end
            ptme_pkg::S_LINK:
            begin
                cmd.link_wr = 1'b1;
            end
            ptme_pkg::S_NEXT:
            begin
            end
            ptme_pkg::S_LEAF:
            begin
                cmd.leaf_wr = 1'b1;
            end
            ptme_pkg::S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ptme_dp.sv
// ----------------------------------------------------------------------------
// ptme_dp: walk datapath
// Table store, request registers, walk pointers, bump allocator, pool base
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptme_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ptme_pkg::PA_W-1:0]     cfg_wr_data,
    input  wire logic [1:0]                    kind,
    input  wire logic [ptme_pkg::VA_W-1:0]     vaddr,
    input  wire logic [ptme_pkg::PA_W-1:0]     paddr,
    input  wire logic [ptme_pkg::FLAGS_W-1:0]  flags,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [2:0]                         status,
    output logic                               invalidate,
    output logic [ptme_pkg::VPN_W-1:0]         invalidate_page,
    input  wire ptme_pkg::ptme_cmd_t           cmd,
    output ptme_pkg::ptme_stat_t               stat
);

    localparam int TW = ptme_pkg::TBL_W;
    localparam int IW = ptme_pkg::IDX_W;
    localparam int AW = ptme_pkg::MEM_AW;
    localparam int CW = ptme_pkg::CNT_W;
    localparam int FW = ptme_pkg::FRAME_W;
    localparam int EW = ptme_pkg::ENTRY_W;

    logic [EW-1:0] mem [ptme_pkg::MEM_DEPTH];

    // control state
    logic [FW-1:0] base_reg;
    logic [CW-1:0] nf_reg;
    logic [AW-1:0] clr_reg;
    logic          out_valid_reg;

    // payload
    logic [1:0]                   kind_reg;
    logic [ptme_pkg::VA_W-1:0]    va_reg;
    logic [ptme_pkg::PA_W-1:0]    pa_reg;
    logic [ptme_pkg::FLAGS_W-1:0] fl_reg;
    logic [1:0]                   level_reg;
    logic [TW-1:0]                cur_reg;
    ptme_pkg::status_t            st_reg;
    logic [EW-1:0]                rdata_reg;
    logic                         ok_reg;
    ptme_pkg::status_t            status_reg;
    logic [ptme_pkg::VPN_W-1:0]   vpn_reg;

    logic [IW-1:0] idx;
    logic [FW-1:0] diff;
    logic [FW-1:0] new_frame;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic          mem_we;
    logic          leaf2;

    // table index for the current level
    always_comb
    begin
        unique case (level_reg)
            ptme_pkg::LVL_PML4: idx = va_reg[47:39];
            ptme_pkg::LVL_PDPT: idx = va_reg[38:30];
            ptme_pkg::LVL_PD:   idx = va_reg[29:21];
            ptme_pkg::LVL_PT:   idx = va_reg[20:12];
            default:            idx = va_reg[20:12];
        endcase
    end

    // pool offset of the entry read, and frame of the next free table
    assign diff      = rdata_reg[51:12] - base_reg;
    assign new_frame = base_reg + FW'(nf_reg);
    assign leaf2     = (level_reg == ptme_pkg::LVL_PD);

    always_comb
    begin
        mem_we    = cmd.clear_wr | cmd.zero_wr | cmd.link_wr | cmd.leaf_wr;
        mem_addr  = {cur_reg, idx};
        mem_wdata = '0;
        priority if (cmd.clear_wr)
        begin
            mem_addr = clr_reg;
        end
        else if (cmd.zero_wr)
        begin
            mem_addr = {nf_reg[TW-1:0], clr_reg[IW-1:0]};
        end
        else if (cmd.link_wr)
        begin
            mem_wdata = {12'h000, new_frame, ptme_pkg::BIT_RW | ptme_pkg::BIT_P};
        end
        else if (cmd.leaf_wr)
        begin
            if (kind_reg[ptme_pkg::KIND_UNMAP_BIT])
            begin
                mem_wdata = '0;
            end
            else if (leaf2)
            begin
                mem_wdata = {12'h000, pa_reg[51:21], 9'h000,
                             fl_reg | ptme_pkg::BIT_P | ptme_pkg::BIT_PS};
            end
            else
            begin
                mem_wdata = {12'h000, pa_reg[51:12], fl_reg | ptme_pkg::BIT_P};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            nf_reg        <= CW'(1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data[51:12];
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= (clr_reg == AW'(ptme_pkg::MEM_DEPTH - 1)) ? '0 : clr_reg + 1'b1;
            end
            else if (cmd.zero_wr)
            begin
                clr_reg <= {{(AW - IW){1'b0}}, clr_reg[IW-1:0] + 1'b1};
            end
            if (cmd.link_wr)
            begin
                nf_reg <= nf_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg  <= kind;
            va_reg    <= vaddr;
            pa_reg    <= paddr;
            fl_reg    <= flags;
            level_reg <= ptme_pkg::LVL_PML4;
            cur_reg   <= '0;
            st_reg    <= ptme_pkg::ST_DONE;
        end
        else if (cmd.follow)
        begin
            cur_reg   <= diff[TW-1:0];
            level_reg <= level_reg + 1'b1;
        end
        else if (cmd.link_wr)
        begin
            cur_reg   <= nf_reg[TW-1:0];
            level_reg <= level_reg + 1'b1;
        end
        if (cmd.fail)
        begin
            st_reg <= cmd.fail_code;
        end
        if (cmd.load_out)
        begin
            ok_reg     <= (st_reg == ptme_pkg::ST_DONE);
            status_reg <= st_reg;
            vpn_reg    <= (st_reg == ptme_pkg::ST_DONE) ? va_reg[47:12] : '0;
        end
    end

    always_comb
    begin
        stat.clear_last = (clr_reg == AW'(ptme_pkg::MEM_DEPTH - 1));
        stat.zero_last  = (clr_reg[IW-1:0] == IW'(ptme_pkg::ENTRIES - 1));
        stat.present    = rdata_reg[0];
        stat.ps_set     = rdata_reg[ptme_pkg::PS_POS];
        stat.in_pool    = (diff < FW'(ptme_pkg::NUM_TABLES));
        stat.pool_full  = (nf_reg >= CW'(ptme_pkg::NUM_TABLES));
        stat.unmap      = kind_reg[ptme_pkg::KIND_UNMAP_BIT];
        stat.large_req  = (kind_reg == ptme_pkg::KIND_MAP_2M);
        stat.level      = level_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign status          = status_reg;
    assign invalidate      = ok_reg;
    assign invalidate_page = vpn_reg;

endmodule

`default_nettype wire

>>> rtl/page_table_map_unmap_engine.sv
// ----------------------------------------------------------------------------
// page_table_map_unmap_engine: x86-64 four-level page table update engine
// Maps 4 KiB or 2 MiB pages and unmaps 4 KiB pages in tables held in an
// internal pool, reporting status and an invalidate indication per request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole table pool, one
// entry per cycle, and keeps in_stall high until it is finished; pool_base
// can be written meanwhile. Requests are handled one at a time. Each level
// of the walk reads the single-port table store, checks the entry and
// advances, and every table the allocator hands out has its 512 entries
// zeroed one per cycle before it is linked. A finished result sits in the
// output register while the next request is already accepted and walked.
// kind 0 maps a 4 KiB page, kind 1 a 2 MiB page, kinds 2 and 3 unmap a 4 KiB
// page. status: 0 done, 1 pool exhausted, 2 level not present, 3 large page
// at directory, 4 entry outside pool. invalidate and invalidate_page are set
// only on success. Write pool_base only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_map_unmap_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: pool_base
    input  wire logic                          cfg_wr_en,
    input  wire logic [ptme_pkg::PA_W-1:0]     cfg_wr_data,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [ptme_pkg::VA_W-1:0]     vaddr,
    input  wire logic [ptme_pkg::PA_W-1:0]     paddr,
    input  wire logic [ptme_pkg::FLAGS_W-1:0]  flags,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [2:0]                         status,
    output logic                               invalidate,
    output logic [ptme_pkg::VPN_W-1:0]         invalidate_page
);

    ptme_pkg::ptme_cmd_t  cmd;
    ptme_pkg::ptme_stat_t stat;

    // walk sequencing
    ptme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table store, allocator and result register
    ptme_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .kind            (kind),
        .vaddr           (vaddr),
        .paddr           (paddr),
        .flags           (flags),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .status          (status),
        .invalidate      (invalidate),
        .invalidate_page (invalidate_page),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

`default_nettype wire
